/* rtl/core/id_allocator_free_stack_assert.svh */
// Assertion macros for the id allocator. Each check is sampled on the rising
// clock edge and is switched off while reset is asserted.
`ifndef ID_ALLOCATOR_FREE_STACK_ASSERT_SVH
`define ID_ALLOCATOR_FREE_STACK_ASSERT_SVH

// A condition that must hold at every sampled edge.
`define IFS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequent that must hold in the same cycle as its antecedent.
`define IFS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A consequent that must hold in the cycle after its antecedent.
`define IFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/ifs_pkg.sv */
package ifs_pkg;

    // Stack size and id width.
    localparam int STACK_DEPTH = 256;
    localparam int ID_WIDTH    = 16;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    // The all-ones id is never handed out.
    localparam logic [ID_WIDTH-1:0] INVALID_ID = '1;

    // Operation codes.
    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_INVALID   = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_EXHAUSTED = 2'd3;

    // Access request to the free stack memory.
    typedef struct packed {
        logic                we;
        logic [ADDR_W-1:0]   waddr;
        logic [ID_WIDTH-1:0] wdata;
        logic                re;
        logic [ADDR_W-1:0]   raddr;
    } ram_req_t;

endpackage

/* rtl/core/id_allocator_free_stack.sv */
// Id allocator with a free stack. Pulse start while busy is low to allocate
// (op 0) or release released_id (op 1). Exactly one result per transfer comes
// out on granted_id and status, valid for the single cycle in which done is
// high; the receiver cannot stall it, so it must take it in that cycle. An
// allocate served from the counter, and a refused release, finish without
// leaving idle. An allocate served from the stack reads the memory from idle,
// gets its result in the pop state, and then the shrink pass follows. A
// successful release writes the stack, gives its result at once and then
// runs the shrink pass, which checks the stack top against counter minus one
// through the registered read port of the free stack memory: the look state
// fetches the top, the compare state absorbs it or stops, and a zero stack or
// counter stops it too. Busy stays high until the pass ends.
module id_allocator_free_stack
    import ifs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                op,
    input  logic [ID_WIDTH-1:0] released_id,
    output logic                busy,
    output logic                done,
    output logic [ID_WIDTH-1:0] granted_id,
    output logic [1:0]          status
);

    `include "id_allocator_free_stack_assert.svh"

    // Sequencer states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_LOOK = 2'd2;
    localparam logic [1:0] S_CMP  = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [ID_WIDTH-1:0] fresh_reg, fresh_next;
    logic                done_reg, done_next;
    logic [ID_WIDTH-1:0] granted_reg, granted_next;
    logic [1:0]          status_reg, status_next;

    ram_req_t            ram_req;
    logic [ID_WIDTH-1:0] ram_rdata;
    logic [CNT_W-1:0]    count_dec;
    logic [ID_WIDTH-1:0] fresh_dec;
    logic                accept;

    ifs_stack_ram u_stack_ram
    (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    assign accept    = start && (state_reg == S_IDLE);
    assign count_dec = count_reg - CNT_W'(1);
    assign fresh_dec = fresh_reg - ID_WIDTH'(1);

    // Next-state logic. Every read is issued after the write to the same entry
    // has been clocked in, so read data never needs forwarding.
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        fresh_next   = fresh_reg;
        done_next    = 1'b0;
        granted_next = INVALID_ID;
        status_next  = ST_OK;
        ram_req      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (op == OP_ALLOC)
                    begin
                        if (count_reg != '0)
                        begin
                            // Pop the stack top; data arrives next cycle.
                            ram_req.re    = 1'b1;
                            ram_req.raddr = count_dec[ADDR_W-1:0];
                            count_next    = count_dec;
                            state_next    = S_POP;
                        end
                        else if (fresh_reg == INVALID_ID)
                        begin
                            done_next   = 1'b1;
                            status_next = ST_EXHAUSTED;
                        end
                        else
                        begin
                            done_next    = 1'b1;
                            granted_next = fresh_reg;
                            fresh_next   = fresh_reg + ID_WIDTH'(1);
                        end
                    end
                    else
                    begin
                        if (released_id == INVALID_ID)
                        begin
                            done_next   = 1'b1;
                            status_next = ST_INVALID;
                        end
                        else if (count_reg == CNT_W'(STACK_DEPTH))
                        begin
                            done_next   = 1'b1;
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            // Push the released id, then try to shrink.
                            ram_req.we    = 1'b1;
                            ram_req.waddr = count_reg[ADDR_W-1:0];
                            ram_req.wdata = released_id;
                            count_next    = count_reg + CNT_W'(1);
                            done_next     = 1'b1;
                            state_next    = S_LOOK;
                        end
                    end
                end
            end

            S_POP:
            begin
                done_next    = 1'b1;
                granted_next = ram_rdata;
                state_next   = S_LOOK;
            end

            S_LOOK:
            begin
                // Fetch the top for the next shrink check.
                if ((count_reg != '0) && (fresh_reg != '0))
                begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = count_dec[ADDR_W-1:0];
                    state_next    = S_CMP;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_CMP:
            begin
                // A top just below the counter is absorbed back into it.
                if (ram_rdata == fresh_dec)
                begin
                    count_next = count_dec;
                    fresh_next = ram_rdata;
                    state_next = S_LOOK;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            fresh_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            fresh_reg <= fresh_next;
            done_reg  <= done_next;
        end
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        granted_reg <= granted_next;
        status_reg  <= status_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign granted_id = granted_reg;
    assign status     = status_reg;

    // Checks on the sequencer.
    `IFS_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(STACK_DEPTH), "stack count overflow")
    `IFS_ASSERT_NEXT(a_accept_progress, start && !busy, done_reg || busy, "transfer lost")
    `IFS_ASSERT_IMP(a_done_source, done_reg, $past(start && !busy) || $past(state_reg == S_POP), "spurious result")
    `IFS_ASSERT_NEXT(a_pop_result, state_reg == S_POP, done_reg && (status_reg == ST_OK), "pop gave no result")

endmodule

/* rtl/core/ifs_stack_ram.sv */
module ifs_stack_ram
    import ifs_pkg::*;
(
    input  logic                clk,
    input  ram_req_t            req,
    output logic [ID_WIDTH-1:0] rdata
);

    logic [ID_WIDTH-1:0] mem [STACK_DEPTH];
    logic [ID_WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* tb/tb_id_allocator_free_stack.sv */
module tb_id_allocator_free_stack;
    import ifs_pkg::*;

    // Longest stretch without any transfer before the run is declared hung.
    localparam int QUIET_LIMIT  = 4000;
    // Cycles allowed for a trailing shrink pass once the last result is in.
    localparam int DRAIN_CYCLES = 600;

    // Keeps its own copy of the free stack and the fresh counter, and the
    // results still owed by the block, oldest first.
    class id_pool_scoreboard;
        logic [ID_WIDTH-1:0] free_ids [STACK_DEPTH];
        int unsigned         depth;
        logic [ID_WIDTH-1:0] fresh;
        logic [ID_WIDTH-1:0] pending_grants [$];
        logic [1:0]          pending_codes [$];
        int                  fail_count;

        function new();
            depth      = 0;
            fresh      = '0;
            fail_count = 0;
        endfunction

        // Only the first few mismatches are printed; the rest are counted.
        function void report(string msg);
            fail_count++;
            if (fail_count <= 10)
            begin
                $display("%s", msg);
            end
        endfunction

        // Pull the counter back over freed ids that sit at its top end.
        function void shrink();
            while (depth > 0 && fresh != 0 && free_ids[depth-1] == fresh - 1)
            begin
                depth--;
                fresh = free_ids[depth];
            end
        endfunction

        // Apply one accepted request and queue the result it must produce.
        function void note_request(input logic req_op, input logic [ID_WIDTH-1:0] req_id,
                                   output logic [ID_WIDTH-1:0] grant,
                                   output logic [1:0] code);
            grant = INVALID_ID;
            code  = ST_OK;
            if (req_op == OP_ALLOC)
            begin
                if (depth > 0)
                begin
                    depth--;
                    grant = free_ids[depth];
                    shrink();
                end
                else if (fresh == INVALID_ID)
                begin
                    code = ST_EXHAUSTED;
                end
                else
                begin
                    grant = fresh;
                    fresh = fresh + 1'b1;
                end
            end
            else
            begin
                if (req_id == INVALID_ID)
                begin
                    code = ST_INVALID;
                end
                else if (depth == STACK_DEPTH)
                begin
                    code = ST_FULL;
                end
                else
                begin
                    free_ids[depth] = req_id;
                    depth++;
                    shrink();
                end
            end
            pending_grants.push_back(grant);
            pending_codes.push_back(code);
        endfunction

        // Compare one result against the oldest outstanding expectation.
        function void check_result(input logic [ID_WIDTH-1:0] grant, input logic [1:0] code);
            logic [ID_WIDTH-1:0] want_grant;
            logic [1:0]          want_code;
            if (pending_grants.size() == 0)
            begin
                report($sformatf("unexpected result: granted_id=%0d status=%0d", grant, code));
                return;
            end
            want_grant = pending_grants.pop_front();
            want_code  = pending_codes.pop_front();
            if (grant !== want_grant || code !== want_code)
            begin
                report($sformatf("mismatch: granted_id exp %0d got %0d, status exp %0d got %0d",
                                 want_grant, grant, want_code, code));
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                op = OP_ALLOC;
    logic [ID_WIDTH-1:0] released_id = '0;
    logic                busy;
    logic                done;
    logic [ID_WIDTH-1:0] granted_id;
    logic [1:0]          status;

    id_pool_scoreboard   pool;
    logic [ID_WIDTH-1:0] held_ids [$];
    bit                  track_held = 1'b1;
    int                  burst_left;
    int                  items_sent = 0;
    int                  quiet_cycles = 0;

    always #4 clk = ~clk;

    id_allocator_free_stack dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .op          (op),
        .released_id (released_id),
        .busy        (busy),
        .done        (done),
        .granted_id  (granted_id),
        .status      (status)
    );

    // Result checking and the hang watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                pool.check_result(granted_id, status);
            end
            if ((start && !busy) || done)
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("tb_id_allocator_free_stack: FAIL");
                $finish;
            end
        end
    end

    // Mostly short bursts, now and then a long one with no gaps at all.
    function automatic int next_burst();
        if ($urandom_range(0, 3) == 0)
        begin
            return $urandom_range(20, 60);
        end
        return $urandom_range(0, 8);
    endfunction

    // Present one request, wait for its transfer, then maybe pause.
    task automatic issue(input logic req_op, input logic [ID_WIDTH-1:0] req_id);
        logic [ID_WIDTH-1:0] grant;
        logic [1:0]          code;
        start       <= 1'b1;
        op          <= req_op;
        released_id <= req_id;
        do @(posedge clk); while (busy);
        pool.note_request(req_op, req_id, grant, code);
        items_sent++;
        if (track_held && req_op == OP_ALLOC && code == ST_OK)
        begin
            held_ids.push_back(grant);
        end
        if (burst_left == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
            burst_left = next_burst();
        end
        else
        begin
            burst_left--;
        end
    endtask

    // Hand back one id that is held, usually the newest one.
    task automatic release_held();
        int                  pick;
        logic [ID_WIDTH-1:0] id;
        pick = ($urandom_range(0, 1) == 0) ? held_ids.size() - 1
                                          : $urandom_range(held_ids.size() - 1, 0);
        id = held_ids[pick];
        held_ids.delete(pick);
        issue(OP_RELEASE, id);
    endtask

    // Fill the stack with ids at or above the counter so nothing collapses,
    // bump into the full case, then drain some or all of it again.
    task automatic fill_free_stack();
        while (pool.depth < STACK_DEPTH)
        begin
            issue(OP_RELEASE, ID_WIDTH'($urandom_range(INVALID_ID - 1, pool.fresh)));
        end
        issue(OP_RELEASE, ID_WIDTH'($urandom_range(INVALID_ID - 1, 0)));
        issue(OP_RELEASE, INVALID_ID);
        issue(OP_RELEASE, ID_WIDTH'($urandom_range(INVALID_ID - 1, 0)));
        repeat ($urandom_range(STACK_DEPTH + 4, 10)) issue(OP_ALLOC, ID_WIDTH'($urandom));
    endtask

    // Mostly well-formed allocate and release traffic, with some noise.
    task automatic run_mix(input int count);
        int goal;
        int pick;
        goal = items_sent + count;
        while (items_sent < goal)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45 || (pick < 85 && held_ids.size() == 0))
            begin
                issue(OP_ALLOC, ID_WIDTH'($urandom));
            end
            else if (pick < 80)
            begin
                release_held();
            end
            else if (pick < 85)
            begin
                // Ascending release: the last one sets off a long collapse.
                held_ids.sort();
                foreach (held_ids[i])
                begin
                    issue(OP_RELEASE, held_ids[i]);
                end
                held_ids.delete();
            end
            else if (pick < 90)
            begin
                issue(OP_RELEASE, INVALID_ID);
            end
            else if (pick < 95)
            begin
                issue(OP_RELEASE, ID_WIDTH'($urandom));
            end
            else
            begin
                // Ids from zero up to the counter: already free, held or never issued.
                issue(OP_RELEASE, ID_WIDTH'($urandom_range(pool.fresh, 0)));
            end
        end
    endtask

    initial
    begin
        pool = new();
        burst_left = next_burst();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: counter at zero, invalid and extreme ids,
        // duplicate releases, a collapse chain and bit patterns.
        track_held = 1'b0;
        issue(OP_RELEASE, 16'd0);
        issue(OP_RELEASE, INVALID_ID);
        issue(OP_RELEASE, INVALID_ID - 1);
        issue(OP_ALLOC, '0);
        issue(OP_ALLOC, '1);
        issue(OP_ALLOC, '0);
        issue(OP_ALLOC, '0);
        issue(OP_ALLOC, '0);
        issue(OP_ALLOC, '0);
        issue(OP_RELEASE, 16'd1);
        issue(OP_RELEASE, 16'd2);
        issue(OP_RELEASE, 16'd3);
        issue(OP_RELEASE, 16'd0);
        issue(OP_RELEASE, 16'd0);
        issue(OP_RELEASE, 16'd0);
        issue(OP_ALLOC, '0);
        issue(OP_ALLOC, '0);
        issue(OP_ALLOC, '0);
        issue(OP_ALLOC, '0);
        issue(OP_RELEASE, 16'h5555);
        issue(OP_RELEASE, 16'hAAAA);
        issue(OP_ALLOC, '0);
        issue(OP_ALLOC, '0);

        // Random part, with two passes through a full stack.
        held_ids.push_back(16'd0);
        held_ids.push_back(16'd1);
        track_held = 1'b1;
        run_mix(250);
        fill_free_stack();
        run_mix(150);
        fill_free_stack();
        run_mix(100);
        start <= 1'b0;

        // Wait for every owed result, then let any trailing pass finish.
        while (pool.pending_grants.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pool.fail_count == 0)
        begin
            $display("tb_id_allocator_free_stack: PASS");
        end
        else
        begin
            $display("tb_id_allocator_free_stack: FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/ifs_pkg.sv
rtl/core/ifs_stack_ram.sv
rtl/core/id_allocator_free_stack.sv
tb/tb_id_allocator_free_stack.sv
